@@ rtl/core/bitmap_text_renderer_defines.svh @@
// Assertion helpers shared by the renderer modules.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef BITMAP_TEXT_RENDERER_DEFINES_SVH
`define BITMAP_TEXT_RENDERER_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define BRT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BRT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/brt_pkg.sv @@
package brt_pkg;

	localparam int ScreenWidthDefault = 240;
	localparam int QueueDepthDefault = 4;

	localparam logic [5:0] FontSizeReset = 6'd16;
	localparam logic [5:0] SizeMin = 6'd8;
	localparam logic [5:0] SizeMax = 6'd32;
	localparam logic [7:0] LeadMin = 8'hA1;
	localparam logic [23:0] RowsPerZone = 24'd94;

	localparam logic [23:0] BaseNarrow24 = 24'h04064C;
	localparam logic [23:0] BaseNarrow32 = 24'h0D1A68;
	localparam logic [23:0] BaseWide16 = 24'h000806;
	localparam logic [23:0] BaseWide24 = 24'h041E52;
	localparam logic [23:0] BaseWide32 = 24'h0D3A6E;

	typedef enum logic [1:0] {
		CMD_SET_CURSOR = 2'd0,
		CMD_TEXT = 2'd1,
		CMD_BITMAP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_FONT_SIZE = 2'd0,
		CFG_FORE_COLOR = 2'd1,
		CFG_BACK_COLOR = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_FETCH = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	// One unit of work for the back end: a fetch request or one bitmap byte.
	typedef struct packed {
		kind_t kind;
		logic [23:0] addr;
		logic [7:0] len;
		logic [15:0] px;
		logic [15:0] py;
		logic [7:0] bits;
	} job_t;

	function automatic logic [5:0] eff_size(input logic [5:0] size);
		logic [5:0] s;
		s = size;
		if (s < SizeMin) begin
			s = SizeMin;
		end
		if (s > SizeMax) begin
			s = SizeMax;
		end
		return s;
	endfunction

	// Sizes other than 16, 24 and 32 have no font of their own and start at zero.
	function automatic logic [23:0] font_base(input logic [5:0] size, input logic wide);
		logic [23:0] base;
		base = '0;
		case (size)
			6'd16: begin
				base = wide ? BaseWide16 : '0;
			end
			6'd24: begin
				base = wide ? BaseWide24 : BaseNarrow24;
			end
			6'd32: begin
				base = wide ? BaseWide32 : BaseNarrow32;
			end
			default: begin
				base = '0;
			end
		endcase
		return base;
	endfunction

endpackage

@@ rtl/core/brt_front.sv @@
module brt_front #(
	parameter int SCREEN_WIDTH = brt_pkg::ScreenWidthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [15:0]       start_x,
	input  logic [15:0]       start_y,
	input  logic [7:0]        data_byte,
	input  logic [5:0]        font_size,
	output logic              push,
	output brt_pkg::job_t     push_job,
	input  logic              queue_full
);

	logic [15:0] cursor_x_q, cursor_y_q, origin_x_q, origin_y_q;
	logic [5:0]  row_q;
	logic [1:0]  bir_q;
	logic [2:0]  bpr_q;
	logic        active_q;
	logic [7:0]  lead_q;
	logic        lead_pending_q;

	logic        job_valid_s1;
	logic        is_fetch_s1;
	logic [23:0] idx_s1;
	logic [7:0]  len_s1;
	logic [23:0] base_s1;
	logic [15:0] px_s1, py_s1;
	logic [7:0]  bits_s1;

	logic        accept;
	logic [5:0]  s;
	logic        start, wide, latch_lead, clear_lead, load_cursor, pixel_job;
	logic [23:0] idx;
	logic [5:0]  w;
	logic [2:0]  bpr;
	logic [7:0]  len;
	logic [15:0] new_x;
	logic        wrap;
	logic [1:0]  bir_inc;
	logic [5:0]  row_inc;
	logic        row_end, glyph_done;

	assign in_stall = job_valid_s1 && queue_full;
	assign accept = in_valid && !in_stall;
	assign s = brt_pkg::eff_size(font_size);

	always_comb begin
		start = 1'b0;
		wide = 1'b0;
		latch_lead = 1'b0;
		clear_lead = 1'b0;
		load_cursor = 1'b0;
		pixel_job = 1'b0;
		idx = 24'(data_byte);
		case (brt_pkg::cmd_t'(command))
			brt_pkg::CMD_SET_CURSOR: begin
				load_cursor = 1'b1;
				clear_lead = 1'b1;
			end
			brt_pkg::CMD_TEXT: begin
				if (lead_pending_q) begin
					// Any second byte completes the pair; a low one wraps the index.
					start = 1'b1;
					wide = 1'b1;
					clear_lead = 1'b1;
					idx = 24'((24'(lead_q) - 24'(brt_pkg::LeadMin)) * brt_pkg::RowsPerZone)
						+ (24'(data_byte) - 24'(brt_pkg::LeadMin));
				end else if (data_byte == 8'd0) begin
					start = 1'b0;
				end else if (data_byte >= brt_pkg::LeadMin) begin
					latch_lead = 1'b1;
				end else begin
					start = 1'b1;
				end
			end
			brt_pkg::CMD_BITMAP: begin
				pixel_job = active_q;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	assign w = wide ? s : {1'b0, s[5:1]};
	assign bpr = 3'((w + 6'd7) >> 3);
	assign len = 8'(bpr) * 8'(s);
	assign new_x = cursor_x_q + 16'(w);
	assign wrap = 32'(new_x) > (32'(SCREEN_WIDTH) - 32'(w));

	assign bir_inc = bir_q + 2'd1;
	assign row_end = (3'(bir_inc) >= bpr_q) || (bir_inc == 2'd0);
	assign row_inc = row_q + 6'd1;
	assign glyph_done = row_inc >= s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			row_q <= '0;
			bir_q <= '0;
			bpr_q <= 3'd1;
			active_q <= 1'b0;
			lead_q <= '0;
			lead_pending_q <= 1'b0;
			job_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (load_cursor) begin
					cursor_x_q <= start_x;
					cursor_y_q <= start_y;
				end
				if (clear_lead) begin
					lead_pending_q <= 1'b0;
				end
				if (latch_lead) begin
					lead_q <= data_byte;
					lead_pending_q <= 1'b1;
				end
				if (start) begin
					origin_x_q <= cursor_x_q;
					origin_y_q <= cursor_y_q;
					row_q <= '0;
					bir_q <= '0;
					bpr_q <= bpr;
					active_q <= 1'b1;
					if (wrap) begin
						cursor_x_q <= '0;
						cursor_y_q <= cursor_y_q + 16'(s);
					end else begin
						cursor_x_q <= new_x;
					end
				end
				if (pixel_job) begin
					if (row_end) begin
						bir_q <= '0;
						if (glyph_done) begin
							row_q <= '0;
							active_q <= 1'b0;
						end else begin
							row_q <= row_inc;
						end
					end else begin
						bir_q <= bir_inc;
					end
				end
			end
			if (accept && (start || pixel_job)) begin
				job_valid_s1 <= 1'b1;
			end else if (!queue_full) begin
				job_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (start || pixel_job)) begin
			is_fetch_s1 <= start;
			idx_s1 <= idx;
			len_s1 <= len;
			base_s1 <= brt_pkg::font_base(s, wide);
			px_s1 <= origin_x_q + 16'({bir_q, 3'b000});
			py_s1 <= origin_y_q + 16'(row_q);
			bits_s1 <= data_byte;
		end
	end

	// The address product is taken from registered operands, one stage after accept.
	assign push = job_valid_s1;
	always_comb begin
		push_job.kind = is_fetch_s1 ? brt_pkg::KIND_FETCH : brt_pkg::KIND_PIXEL;
		push_job.addr = is_fetch_s1 ? (base_s1 + 24'(idx_s1 * 24'(len_s1))) : '0;
		push_job.len = is_fetch_s1 ? len_s1 : '0;
		push_job.px = px_s1;
		push_job.py = py_s1;
		push_job.bits = bits_s1;
	end

endmodule

@@ rtl/core/brt_queue.sv @@
`include "bitmap_text_renderer_defines.svh"

module brt_queue #(
	parameter int DEPTH = brt_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output brt_pkg::job_t pop_job,
	output logic          empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	brt_pkg::job_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == CntW'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`BRT_ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= DEPTH, "queue count above depth")
	`BRT_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from an empty queue")

endmodule

@@ rtl/core/brt_back.sv @@
`include "bitmap_text_renderer_defines.svh"

module brt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  brt_pkg::job_t job,
	output logic          pop,
	input  logic [15:0]   fore_color,
	input  logic [15:0]   back_color,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          kind,
	output logic [23:0]   fetch_address,
	output logic [7:0]    fetch_length,
	output logic [15:0]   pixel_x,
	output logic [15:0]   pixel_y,
	output logic [15:0]   pixel_color,
	output logic          last
);

	logic        out_valid_q;
	logic        kind_q, last_q;
	logic [23:0] addr_q;
	logic [7:0]  len_q;
	logic [15:0] px_q, py_q, color_q;

	logic        busy_q;
	logic [2:0]  j_q;
	logic [15:0] cur_px_q, cur_py_q;
	logic [7:0]  cur_bits_q;

	logic        out_free, load;
	logic        load_fetch;
	logic [15:0] src_px, src_py;
	logic [7:0]  src_bits;
	logic [2:0]  src_j;

	assign out_free = !out_valid_q || !out_stall;
	assign pop = out_free && !busy_q && job_valid;
	assign load = out_free && (busy_q || job_valid);
	assign load_fetch = !busy_q && (job.kind == brt_pkg::KIND_FETCH);

	// A bitmap byte is expanded from its held copy once the first pixel is out.
	always_comb begin
		if (busy_q) begin
			src_px = cur_px_q;
			src_py = cur_py_q;
			src_bits = cur_bits_q;
			src_j = j_q;
		end else begin
			src_px = job.px;
			src_py = job.py;
			src_bits = job.bits;
			src_j = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
			j_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (out_free) begin
				if (busy_q) begin
					j_q <= j_q + 3'd1;
					if (j_q == 3'd7) begin
						busy_q <= 1'b0;
					end
				end else if (job_valid && !load_fetch) begin
					busy_q <= 1'b1;
					j_q <= 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !load_fetch) begin
			cur_px_q <= job.px;
			cur_py_q <= job.py;
			cur_bits_q <= job.bits;
		end
		if (load) begin
			if (load_fetch) begin
				kind_q <= brt_pkg::KIND_FETCH;
				addr_q <= job.addr;
				len_q <= job.len;
				px_q <= '0;
				py_q <= '0;
				color_q <= '0;
				last_q <= 1'b1;
			end else begin
				kind_q <= brt_pkg::KIND_PIXEL;
				addr_q <= '0;
				len_q <= '0;
				px_q <= src_px + 16'(src_j);
				py_q <= src_py;
				color_q <= src_bits[3'd7 - src_j] ? fore_color : back_color;
				last_q <= src_j == 3'd7;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign fetch_address = addr_q;
	assign fetch_length = len_q;
	assign pixel_x = px_q;
	assign pixel_y = py_q;
	assign pixel_color = color_q;
	assign last = last_q;

	`BRT_ASSERT_SAME(a_fetch_last, out_valid_q && (kind_q == brt_pkg::KIND_FETCH), last_q, "fetch without last")
	`BRT_ASSERT_NEXT(a_pixel_run, out_valid_q && !out_stall && (kind_q == brt_pkg::KIND_PIXEL) && !last_q, out_valid_q && (kind_q == brt_pkg::KIND_PIXEL), "pixel run broken")
	`BRT_ASSERT_SAME(a_no_pop_busy, busy_q, !pop, "queue popped mid byte")

endmodule

@@ rtl/core/bitmap_text_renderer.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    command, start_x, start_y, data_byte
// result    out        out_valid/out_stall  kind, fetch_address, fetch_length,
//                                           pixel_x, pixel_y, pixel_color, last
// config    in         cfg_write            cfg_index, cfg_data
//
// A text item that starts a glyph gives one fetch request; a bitmap byte of an active
// glyph gives eight pixel writes, one per cycle while out_stall is low, from the
// pixel sequencer in the back end. An accepted item passes the front-end job register
// and the job queue to reach the output register. Set-cursor and lead bytes give nothing.
// Reset clears the cursor, the glyph state and the queue; font_size resets to 16.
// The input stalls only when the job queue is full and a job waits to enter it.
module bitmap_text_renderer #(
	parameter int SCREEN_WIDTH = brt_pkg::ScreenWidthDefault,
	parameter int QUEUE_DEPTH = brt_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [23:0] fetch_address,
	output logic [7:0]  fetch_length,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [15:0] pixel_color,
	output logic        last,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [5:0]  font_size_q;
	logic [15:0] fore_color_q, back_color_q;

	logic          push, queue_full, pop, queue_empty;
	brt_pkg::job_t push_job, pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_size_q <= brt_pkg::FontSizeReset;
			fore_color_q <= '0;
			back_color_q <= '0;
		end else if (cfg_write) begin
			case (brt_pkg::cfg_reg_t'(cfg_index))
				brt_pkg::CFG_FONT_SIZE: begin
					font_size_q <= cfg_data[5:0];
				end
				brt_pkg::CFG_FORE_COLOR: begin
					fore_color_q <= cfg_data;
				end
				brt_pkg::CFG_BACK_COLOR: begin
					back_color_q <= cfg_data;
				end
				default: begin
					font_size_q <= font_size_q;
				end
			endcase
		end
	end

	brt_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.start_x(start_x),
		.start_y(start_y),
		.data_byte(data_byte),
		.font_size(font_size_q),
		.push(push),
		.push_job(push_job),
		.queue_full(queue_full)
	);

	brt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(queue_full),
		.pop(pop),
		.pop_job(pop_job),
		.empty(queue_empty)
	);

	brt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!queue_empty),
		.job(pop_job),
		.pop(pop),
		.fore_color(fore_color_q),
		.back_color(back_color_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.fetch_address(fetch_address),
		.fetch_length(fetch_length),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last(last)
	);

endmodule
